// ----- rtl/mpmc_pkg.sv -----
// Shared types and constants of the multi-pattern match counter.
`timescale 1ns / 1ps

package mpmc_pkg;

  localparam int unsigned NumPatterns = 16;
  localparam int unsigned MaxLen      = 16;
  localparam int unsigned MaxReports  = 16;
  localparam int unsigned CountW      = 32;
  // common width for length, fill and position compares (holds MAX_LEN up to 255)
  localparam int unsigned CmpW        = 8;

  typedef enum logic [1:0] {
    FuncPatByte = 2'd0,
    FuncPatLen  = 2'd1,
    FuncText    = 2'd2,
    FuncEnd     = 2'd3
  } mpmc_func_e;

  typedef struct packed {
    mpmc_func_e  func;
    logic [3:0]  pattern_index;
    logic [3:0]  char_position;
    logic [7:0]  byte_value;
    logic [4:0]  pattern_length;
  } mpmc_in_t;

  typedef struct packed {
    logic [3:0]  result_pattern;
    logic [31:0] occurrence_count;
    logic        last_result;
  } mpmc_out_t;

  typedef struct packed {
    logic text_en;
    logic end_en;
    logic rep_shift;
  } mpmc_ctrl_t;

endpackage

// ----- rtl/mpmc_text_cell.sv -----
// One byte of the text window shift chain.
`timescale 1ns / 1ps

module mpmc_text_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpmc_pkg::mpmc_ctrl_t  ctrl_i,
  input  logic [7:0]            byte_i,
  output logic [7:0]            byte_o
);
  import mpmc_pkg::*;

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.end_en) begin
      byte_d = '0;
    end else if (ctrl_i.text_en) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// ----- rtl/mpmc_pattern_cell.sv -----
// One pattern: its bytes, length, tail compare, saturating count and report stage.
`timescale 1ns / 1ps

module mpmc_pattern_cell #(
  parameter int unsigned MAX_LEN = mpmc_pkg::MaxLen
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mpmc_pkg::mpmc_ctrl_t            ctrl_i,
  input  logic                            byte_we_i,
  input  logic                            len_we_i,
  input  logic [mpmc_pkg::CmpW-1:0]       pos_i,
  input  logic [7:0]                      byte_i,
  input  logic [4:0]                      len_i,
  input  logic [mpmc_pkg::CmpW-1:0]       fill_i,
  input  logic [MAX_LEN-1:0][7:0]         win_i,
  input  logic [mpmc_pkg::CountW-1:0]     rep_i,
  output logic [mpmc_pkg::CountW-1:0]     rep_o
);
  import mpmc_pkg::*;

  localparam int unsigned IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [MAX_LEN-1:0][7:0]      pat_q;
  logic [4:0]                   len_q;
  logic [CountW-1:0]            cnt_q, cnt_d, cnt_next, rep_q;
  logic                         hit_q, hit_d;
  logic [MAX_LEN-1:0]           byte_ok;
  logic [MAX_LEN-1:0][CmpW-1:0] tap_idx;
  logic [CmpW-1:0]              len_ext;

  // pattern byte k lines up with window entry len-1-k (entry 0 is newest)
  always_comb begin
    len_ext = CmpW'(len_q);
    for (int k = 0; k < MAX_LEN; k++) begin
      tap_idx[k] = len_ext - CmpW'(k) - CmpW'(1);
      byte_ok[k] = (CmpW'(k) >= len_ext) || (pat_q[k] == win_i[tap_idx[k][IdxW-1:0]]);
    end
    hit_d = ctrl_i.text_en && (len_q != '0) && (len_ext <= fill_i) && (&byte_ok);
  end

  always_comb begin
    cnt_next = (hit_q && (cnt_q != '1)) ? cnt_q + CountW'(1) : cnt_q;
    cnt_d    = ctrl_i.end_en ? '0 : cnt_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      cnt_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (len_we_i) begin
        len_q <= len_i;
      end
      cnt_q <= cnt_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we_i) begin
      for (int k = 0; k < MAX_LEN; k++) begin
        if (pos_i == CmpW'(k)) begin
          pat_q[k] <= byte_i;
        end
      end
    end
  end

  // report stage: snapshot takes any hit still pending from the last text item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.end_en) begin
      rep_q <= cnt_next;
    end else if (ctrl_i.rep_shift) begin
      rep_q <= rep_i;
    end
  end

  assign rep_o = rep_q;

endmodule

// ----- rtl/multi_pattern_match_counter_unit.sv -----
// Top level of the multi-pattern match counter.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes pattern byte writes,
//   pattern length writes, text bytes and end-of-text items, one item per cycle
//   while in_stall_o is low. Text bytes shift a window chain; every pattern cell
//   compares its bytes with the window tail in the cycle the byte is taken,
//   registers the hit and then adds it to its count. An end-of-text item loads
//   each cell's count into its report stage and clears the counts and window.
//   Reports then shift along the cells towards pattern 0, one per cycle while
//   out_stall_i is low, at the output (out_valid_o / out_stall_i / out_item_o),
//   first valid the cycle after end-of-text is taken; the last one is marked.
//   Pattern and text items are taken while reports drain; a further end-of-text
//   item is held off until the final report of the previous run is being taken.
//   A stalled output keeps its item unchanged and only holds the report chain.
//   Configuration: cfg_we_i writes patterns_in_use from cfg_wdata_i.
//   Reset clears lengths, counts, window, fill and patterns_in_use; pattern bytes
//   hold nothing defined until written.
`timescale 1ns / 1ps

module multi_pattern_match_counter_unit #(
  parameter int unsigned NUM_PATTERNS = mpmc_pkg::NumPatterns,
  parameter int unsigned MAX_LEN      = mpmc_pkg::MaxLen
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mpmc_pkg::mpmc_in_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mpmc_pkg::mpmc_out_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i
);
  import mpmc_pkg::*;

  localparam int unsigned RepMax = (NUM_PATTERNS < MaxReports) ? NUM_PATTERNS : MaxReports;

  logic [4:0]                         in_use_q;
  logic [4:0]                         rem_q, rem_d, n_rep;
  logic [3:0]                         idx_q, idx_d;
  logic [CmpW-1:0]                    fill_q, fill_d, fill_new;
  logic [CmpW-1:0]                    pidx_ext, pos_ext;
  logic                               in_acc, out_acc, busy;
  mpmc_ctrl_t                         ctrl;
  logic [MAX_LEN-1:0][7:0]            win_q, win_new;
  logic [NUM_PATTERNS:0][CountW-1:0]  rep_chain;
  logic [NUM_PATTERNS-1:0]            byte_we, len_we;

  assign busy       = (rem_q > 5'd1) || ((rem_q == 5'd1) && out_stall_i);
  assign in_stall_o = (in_item_i.func == FuncEnd) && busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  always_comb begin
    ctrl.text_en   = in_acc && (in_item_i.func == FuncText);
    ctrl.end_en    = in_acc && (in_item_i.func == FuncEnd);
    ctrl.rep_shift = out_acc;
  end

  assign pidx_ext = CmpW'(in_item_i.pattern_index);
  assign pos_ext  = CmpW'(in_item_i.char_position);

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      byte_we[p] = in_acc && (in_item_i.func == FuncPatByte) &&
                   (pidx_ext == CmpW'(p)) && (pos_ext < CmpW'(MAX_LEN));
      len_we[p]  = in_acc && (in_item_i.func == FuncPatLen) && (pidx_ext == CmpW'(p));
    end
  end

  // window after the incoming byte, as the cells will hold it
  always_comb begin
    win_new[0] = in_item_i.byte_value;
    for (int i = 1; i < MAX_LEN; i++) begin
      win_new[i] = win_q[i-1];
    end
  end

  assign fill_new = (fill_q < CmpW'(MAX_LEN)) ? fill_q + CmpW'(1) : fill_q;

  always_comb begin
    fill_d = fill_q;
    if (ctrl.end_en) begin
      fill_d = '0;
    end else if (ctrl.text_en) begin
      fill_d = fill_new;
    end
  end

  assign n_rep = (in_use_q > 5'(RepMax)) ? 5'(RepMax) : in_use_q;

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (ctrl.end_en) begin
      rem_d = n_rep;
      idx_d = '0;
    end else if (out_acc) begin
      rem_d = rem_q - 5'd1;
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      rem_q    <= '0;
      idx_q    <= '0;
      fill_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        in_use_q <= cfg_wdata_i;
      end
      rem_q  <= rem_d;
      idx_q  <= idx_d;
      fill_q <= fill_d;
    end
  end

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_text
    mpmc_text_cell u_text_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i (win_new[i]),
      .byte_o (win_q[i])
    );
  end

  assign rep_chain[NUM_PATTERNS] = '0;

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_pat
    mpmc_pattern_cell #(
      .MAX_LEN (MAX_LEN)
    ) u_pattern_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_we_i (byte_we[p]),
      .len_we_i  (len_we[p]),
      .pos_i     (pos_ext),
      .byte_i    (in_item_i.byte_value),
      .len_i     (in_item_i.pattern_length),
      .fill_i    (fill_new),
      .win_i     (win_new),
      .rep_i     (rep_chain[p+1]),
      .rep_o     (rep_chain[p])
    );
  end

  assign out_valid_o = (rem_q != '0);

  always_comb begin
    out_item_o.result_pattern   = idx_q;
    out_item_o.occurrence_count = rep_chain[0];
    out_item_o.last_result      = (rem_q == 5'd1);
  end

endmodule

// ----- verif/tb_multi_pattern_match_counter_unit.sv -----
// Self-checking testbench for the multi-pattern match counter: directed and random item streams.
`timescale 1ns / 1ps

module tb_multi_pattern_match_counter_unit;
  import mpmc_pkg::*;

  localparam logic [7:0] ChA = 8'h61;
  localparam logic [7:0] ChB = 8'h62;
  localparam int unsigned RandomItems = 245;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  mpmc_in_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  mpmc_out_t  out_item_o;
  logic       cfg_we_i    = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  // predicted state of the block
  logic [7:0]  pat_bytes [NumPatterns][MaxLen];
  logic [4:0]  pat_len [NumPatterns];
  logic [7:0]  text_win [MaxLen];
  int unsigned win_fill;
  logic [31:0] hit_count [NumPatterns];
  logic [4:0]  reports_in_use;
  mpmc_out_t   exp_reports [$];

  // pattern bytes already loaded, so that no unwritten byte is ever compared
  bit [MaxLen-1:0] byte_written [NumPatterns];
  bit              no_gaps;
  int unsigned     items_sent;
  int unsigned     mismatches;
  int unsigned     out_hold;

  multi_pattern_match_counter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_text_state();
    for (int i = 0; i < MaxLen; i++) text_win[i] = '0;
    for (int p = 0; p < NumPatterns; p++) hit_count[p] = '0;
    win_fill = 0;
  endfunction

  function automatic void clear_prediction();
    for (int p = 0; p < NumPatterns; p++) begin
      pat_len[p] = '0;
      byte_written[p] = '0;
      for (int k = 0; k < MaxLen; k++) pat_bytes[p][k] = '0;
    end
    reports_in_use = '0;
    clear_text_state();
  endfunction

  function automatic void predict_counts(input mpmc_in_t it);
    int unsigned p, k, len, n;
    bit hit;
    mpmc_out_t r;
    case (it.func)
      FuncPatByte: pat_bytes[it.pattern_index][it.char_position] = it.byte_value;
      FuncPatLen:  pat_len[it.pattern_index] = it.pattern_length;
      FuncText: begin
        for (k = MaxLen - 1; k > 0; k--) text_win[k] = text_win[k - 1];
        text_win[0] = it.byte_value;
        if (win_fill < MaxLen) win_fill++;
        for (p = 0; p < NumPatterns; p++) begin
          len = pat_len[p];
          hit = (len != 0) && (len <= win_fill);
          // pattern byte 0 lines up with the oldest byte of the tail
          for (k = 0; hit && k < len; k++) begin
            if (pat_bytes[p][k] !== text_win[len - 1 - k]) hit = 1'b0;
          end
          if (hit && hit_count[p] != '1) hit_count[p]++;
        end
      end
      FuncEnd: begin
        n = reports_in_use;
        if (n > NumPatterns) n = NumPatterns;
        if (n > MaxReports) n = MaxReports;
        for (p = 0; p < n; p++) begin
          r.result_pattern   = p[3:0];
          r.occurrence_count = hit_count[p];
          r.last_result      = (p + 1 == n);
          exp_reports = {exp_reports, r};
        end
        clear_text_state();
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic check_report(input mpmc_out_t got);
    mpmc_out_t want;
    if (exp_reports.size() == 0) begin
      note_mismatch($sformatf("unexpected count: pattern %0d count %0d last %0b",
                              got.result_pattern, got.occurrence_count, got.last_result));
      return;
    end
    want = exp_reports.pop_front();
    if (got.result_pattern !== want.result_pattern ||
        got.occurrence_count !== want.occurrence_count ||
        got.last_result !== want.last_result) begin
      note_mismatch($sformatf(
        "count mismatch: exp pattern %0d count %0d last %0b, got pattern %0d count %0d last %0b",
        want.result_pattern, want.occurrence_count, want.last_result,
        got.result_pattern, got.occurrence_count, got.last_result));
    end
  endtask

  // output side: random hold-off before each count is taken
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      check_report(out_item_o);
      out_hold = no_gaps ? 0 : $urandom_range(0, 7);
    end
    if (out_hold != 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(input mpmc_in_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_counts(it);
    items_sent++;
  endtask

  // the last item must not stay valid while the sender waits
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_reports.size() != 0);
  endtask

  task automatic write_patterns_in_use(input logic [4:0] value);
    wait_drained();
    // a text byte may still be counting
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    reports_in_use = value;
    cfg_we_i <= 1'b0;
  endtask

  // unused fields carry random bits
  function automatic mpmc_in_t blank_item(input mpmc_func_e f);
    logic [22:0] raw;
    mpmc_in_t it;
    raw = 23'($urandom);
    it = raw;
    it.func = f;
    return it;
  endfunction

  task automatic put_pattern_byte(input int p, input int pos, input logic [7:0] b);
    mpmc_in_t it;
    it = blank_item(FuncPatByte);
    it.pattern_index = p[3:0];
    it.char_position = pos[3:0];
    it.byte_value    = b;
    send_item(it);
    byte_written[p][pos] = 1'b1;
  endtask

  task automatic set_length(input int p, input int len);
    mpmc_in_t it;
    it = blank_item(FuncPatLen);
    it.pattern_index  = p[3:0];
    it.pattern_length = len[4:0];
    send_item(it);
  endtask

  task automatic put_text(input logic [7:0] b);
    mpmc_in_t it;
    it = blank_item(FuncText);
    it.byte_value = b;
    send_item(it);
  endtask

  task automatic end_text();
    send_item(blank_item(FuncEnd));
  endtask

  function automatic int unsigned written_prefix(input int p);
    int unsigned n;
    n = 0;
    while (n < MaxLen && byte_written[p][n]) n++;
    return n;
  endfunction

  // small alphabet so that matches are frequent, with the odd arbitrary byte
  function automatic logic [7:0] text_char(input bit mostly_a);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 15) return 8'($urandom);
    if (mostly_a) return (r == 14) ? ChB : ChA;
    return r[0] ? ChB : ChA;
  endfunction

  task automatic pick_length(input int p);
    int unsigned pre, r, len;
    pre = written_prefix(p);
    r = $urandom_range(0, 9);
    if (r == 0) len = 0;
    else if (r == 1) len = $urandom_range(MaxLen + 1, 31);
    else len = (pre == 0) ? 0 : $urandom_range(1, pre);
    set_length(p, len);
  endtask

  task automatic test_empty_report();
    end_text();  // nothing in use after reset
    write_patterns_in_use(5'd16);
  endtask

  task automatic test_extreme_bytes();
    logic [7:0] seq [6] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF};
    put_pattern_byte(0, 0, 8'h00);
    put_pattern_byte(0, 1, 8'h00);
    set_length(0, 2);  // zero window must not count before two bytes are in
    put_pattern_byte(1, 0, 8'hFF);
    set_length(1, 1);
    put_pattern_byte(2, 0, 8'hFF);
    set_length(2, 1);  // duplicate of pattern 1
    set_length(3, 0);
    set_length(4, 31);  // longer than the window
    put_pattern_byte(NumPatterns - 1, MaxLen - 1, 8'hA5);
    foreach (seq[i]) put_text(seq[i]);
    end_text();
  endtask

  task automatic test_overlap();
    write_patterns_in_use(5'd31);
    put_pattern_byte(5, 0, ChA);
    put_pattern_byte(5, 1, ChA);
    set_length(5, 2);
    repeat (4) put_text(ChA);
    end_text();
    wait_drained();
  endtask

  task automatic test_short_report();
    write_patterns_in_use(5'd1);
    put_text(8'h00);
    put_text(8'h00);
    end_text();
    write_patterns_in_use(5'd0);
    put_text(ChA);
    end_text();
  endtask

  task automatic test_random_streams();
    int unsigned target, p, q, k, len, ntext;
    logic [4:0] v;
    bit mostly_a;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      no_gaps  = ($urandom_range(0, 3) == 0);
      mostly_a = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       v = 5'd0;
          1:       v = 5'd31;
          2:       v = 5'd16;
          default: v = 5'($urandom_range(0, 31));
        endcase
        write_patterns_in_use(v);
      end
      repeat ($urandom_range(1, 4)) begin
        p = $urandom_range(0, NumPatterns - 1);
        case ($urandom_range(0, 9))
          0: begin
            for (k = 0; k < MaxLen; k++) put_pattern_byte(p, k, mostly_a ? ChA : text_char(0));
            set_length(p, MaxLen);
          end
          1, 2: begin
            q = $urandom_range(0, NumPatterns - 1);
            len = pat_len[q];
            for (k = 0; len <= MaxLen && k < len; k++) put_pattern_byte(p, k, pat_bytes[q][k]);
            set_length(p, len);
          end
          3: pick_length(p);
          default: begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) put_pattern_byte(p, k, text_char(mostly_a));
            set_length(p, len);
          end
        endcase
      end
      ntext = $urandom_range(4, mostly_a ? 30 : 16);
      repeat (ntext) begin
        if ($urandom_range(0, 11) == 0) begin
          p = $urandom_range(0, NumPatterns - 1);
          if ($urandom_range(0, 1) == 0)
            put_pattern_byte(p, $urandom_range(0, MaxLen - 1), text_char(mostly_a));
          else
            pick_length(p);
        end
        put_text(text_char(mostly_a));
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
      end_text();
    end
  endtask

  initial begin
    clear_prediction();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_report();
    test_extreme_bytes();
    test_overlap();
    test_short_report();
    test_random_streams();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_multi_pattern_match_counter_unit: PASS");
    end else begin
      $display("tb_multi_pattern_match_counter_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_multi_pattern_match_counter_unit: FAIL");
    $finish;
  end

endmodule
